// ===== rtl/nsv_pkg.sv =====
`default_nettype none

package nsv_pkg;

	localparam int LineCapacityDefault = 512;

	localparam int LenW = 9;

	// character codes
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChStar   = 8'h2A;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChLf     = 8'h0A;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_STAR  = 2'd1,
		STATUS_BAD_HEX  = 2'd2,
		STATUS_MISMATCH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_GPRMC = 2'd1,
		KIND_GNGLL = 2'd2,
		KIND_GPGGA = 2'd3
	} kind_t;

	typedef struct packed {
		status_t         status;
		kind_t           sentence_kind;
		logic [7:0]      computed_checksum;
		logic [7:0]      received_checksum;
		logic [LenW-1:0] line_length;
	} result_t;

	// talker and type characters after the dollar, one row per kind
	localparam logic [7:0] KindPattern [3][5] = '{
		'{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
		'{8'h47, 8'h4E, 8'h47, 8'h4C, 8'h4C},
		'{8'h47, 8'h50, 8'h47, 8'h47, 8'h41}
	};

	// bit 4 set means not a hex digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nsv_byte_if.sv =====
`default_nettype none

interface nsv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/nsv_result_if.sv =====
`default_nettype none

interface nsv_result_if import nsv_pkg::*; ();
	logic            valid;
	logic            ready;
	status_t         status;
	kind_t           sentence_kind;
	logic [7:0]      computed_checksum;
	logic [7:0]      received_checksum;
	logic [LenW-1:0] line_length;

	modport source (
		output valid, output status, output sentence_kind, output computed_checksum,
		output received_checksum, output line_length, input ready
	);
	modport sink (
		input valid, input status, input sentence_kind, input computed_checksum,
		input received_checksum, input line_length, output ready
	);
endinterface

`default_nettype wire

// ===== rtl/nsv_line_checker.sv =====
`default_nettype none

module nsv_line_checker import nsv_pkg::*; #(
	parameter int LINE_CAPACITY = LineCapacityDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	output      logic       res_valid,
	output      result_t    res
);

	localparam int CntW = $clog2(LINE_CAPACITY);

	logic            in_line_q,   in_line_d;
	logic [CntW-1:0] cnt_q,       cnt_d;
	logic [7:0]      xor_q,       xor_d;
	logic            star_q,      star_d;
	logic [1:0]      digits_q,    digits_d;
	logic [7:0]      dval_q,      dval_d;
	logic            derr_q,      derr_d;
	logic [2:0]      cand_q,      cand_d;

	logic [CntW+LenW-1:0] len_ext;
	logic [CntW-1:0]      cnt_inc;
	logic [4:0]           hex;
	logic [2:0]           pat_idx;

	assign cnt_inc = cnt_q + CntW'(1);
	assign len_ext = {{LenW{1'b0}}, cnt_inc};
	assign hex     = hex_decode(rx_byte);
	assign pat_idx = cnt_q[2:0] - 3'd1;

	always_comb begin
		in_line_d = in_line_q;
		cnt_d     = cnt_q;
		xor_d     = xor_q;
		star_d    = star_q;
		digits_d  = digits_q;
		dval_d    = dval_q;
		derr_d    = derr_q;
		cand_d    = cand_q;
		res_valid = 1'b0;

		res.status            = STATUS_NO_STAR;
		res.sentence_kind     = KIND_OTHER;
		res.computed_checksum = xor_q;
		res.received_checksum = 8'h00;
		res.line_length       = len_ext[LenW-1:0];

		if (cand_q[0]) begin
			res.sentence_kind = KIND_GPRMC;
		end else if (cand_q[1]) begin
			res.sentence_kind = KIND_GNGLL;
		end else if (cand_q[2]) begin
			res.sentence_kind = KIND_GPGGA;
		end
		if (cnt_q < CntW'(6)) begin
			res.sentence_kind = KIND_OTHER;
		end

		if (!star_q) begin
			res.status = STATUS_NO_STAR;
		end else if (digits_q < 2'd2 || derr_q) begin
			res.status = STATUS_BAD_HEX;
		end else begin
			res.received_checksum = dval_q;
			res.status = (dval_q == xor_q) ? STATUS_OK : STATUS_MISMATCH;
		end

		if (rx_byte == ChCr) begin
			// carriage return leaves everything untouched
		end else if (rx_byte == ChDollar) begin
			in_line_d = 1'b1;
			cnt_d     = CntW'(1);
			xor_d     = 8'h00;
			star_d    = 1'b0;
			digits_d  = 2'd0;
			dval_d    = 8'h00;
			derr_d    = 1'b0;
			cand_d    = 3'b111;
		end else if (!in_line_q || cnt_q >= CntW'(LINE_CAPACITY - 1)) begin
			in_line_d = 1'b0;
		end else begin
			cnt_d = cnt_inc;
			if (rx_byte == ChLf) begin
				res_valid = 1'b1;
				in_line_d = 1'b0;
			end else begin
				if (cnt_q >= CntW'(1) && cnt_q <= CntW'(5)) begin
					for (int k = 0; k < 3; k++) begin
						if (KindPattern[k][pat_idx] != rx_byte) begin
							cand_d[k] = 1'b0;
						end
					end
				end
				if (!star_q) begin
					if (rx_byte == ChStar) begin
						star_d = 1'b1;
					end else begin
						xor_d = xor_q ^ rx_byte;
					end
				end else if (digits_q < 2'd2) begin
					if (hex[4]) begin
						derr_d = 1'b1;
					end else begin
						dval_d = {dval_q[3:0], hex[3:0]};
					end
					digits_d = digits_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q <= 1'b0;
			cnt_q     <= '0;
			xor_q     <= 8'h00;
			star_q    <= 1'b0;
			digits_q  <= 2'd0;
			dval_q    <= 8'h00;
			derr_q    <= 1'b0;
			cand_q    <= 3'b111;
		end else if (step) begin
			in_line_q <= in_line_d;
			cnt_q     <= cnt_d;
			xor_q     <= xor_d;
			star_q    <= star_d;
			digits_q  <= digits_d;
			dval_q    <= dval_d;
			derr_q    <= derr_d;
			cand_q    <= cand_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/nmea_sentence_validator.sv =====
`default_nettype none

// channel | direction | payload
// --------+-----------+---------------------------------------------------------
// rx      | in        | rx_byte
// res     | out       | status, sentence_kind, computed_checksum,
//         |           | received_checksum, line_length
//
// one byte per cycle while no newline waits on a stalled result; a newline's result
// is registered in the input register, then in the result register
// the line state is updated by one short pass of logic in the second stage
// arst_n clears the line state, the stage valid and the result valid at once
// a stalled result holds the result register; bytes keep flowing through the
// input stage until a newline is held waiting behind the full result register

module nmea_sentence_validator import nsv_pkg::*; #(
	parameter int LINE_CAPACITY = LineCapacityDefault
) (
	input wire logic   clk,
	input wire logic   arst_n,
	nsv_byte_if.sink   rx,
	nsv_result_if.source res
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;

	// checker outputs for the byte in the input register
	logic    chk_valid;
	result_t chk_res;

	logic slot_free;
	logic advance;

	// result slot free or being drained this cycle
	assign slot_free = !res_valid_q || res.ready;
	// a byte that ends no line never needs the result slot
	assign advance   = slot_free || !chk_valid;
	assign rx.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// per-byte line tracking and end-of-line evaluation
	nsv_line_checker #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.rx_byte   (byte_s1),
		.res_valid (chk_valid),
		.res       (chk_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (slot_free) begin
			res_valid_q <= valid_s1 && chk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && valid_s1 && chk_valid) begin
			res_q <= chk_res;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.status            = res_q.status;
	assign res.sentence_kind     = res_q.sentence_kind;
	assign res.computed_checksum = res_q.computed_checksum;
	assign res.received_checksum = res_q.received_checksum;
	assign res.line_length       = res_q.line_length;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

import nsv_pkg::*;

// tracks the line being received and keeps the results it is owed
class line_scoreboard;
	int unsigned capacity;
	bit          in_line;
	int unsigned fill;
	logic [7:0]  xor_sum;
	bit          star_seen;
	int unsigned digit_count;
	logic [7:0]  digit_acc;
	bit          digit_bad;
	bit   [2:0]  kinds_left;
	result_t     expected_q[$];
	int unsigned errors;
	int unsigned checked;

	function new(int unsigned cap);
		capacity   = cap;
		xor_sum    = '0;
		digit_acc  = '0;
		kinds_left = 3'b111;
	endfunction

	task report(string msg);
		errors++;
		$display("mismatch on result %0d: %s", checked, msg);
	endtask

	// one accepted transfer on the byte channel
	function void note_byte(logic [7:0] c);
		string       patt [3];
		int unsigned pos;
		logic [3:0]  nib;
		bit          is_hex;
		result_t     r;
		patt = '{"GPRMC", "GNGLL", "GPGGA"};
		if (c == ChCr) return;
		if (c == ChDollar) begin
			in_line     = 1'b1;
			fill        = 1;
			xor_sum     = '0;
			star_seen   = 1'b0;
			digit_count = 0;
			digit_acc   = '0;
			digit_bad   = 1'b0;
			kinds_left  = 3'b111;
			return;
		end
		if (!in_line || fill >= capacity - 1) begin
			in_line = 1'b0;
			return;
		end
		pos = fill;
		fill++;
		if (c == ChLf) begin
			r.sentence_kind = KIND_OTHER;
			if (pos >= 6) begin
				if (kinds_left[0]) r.sentence_kind = KIND_GPRMC;
				else if (kinds_left[1]) r.sentence_kind = KIND_GNGLL;
				else if (kinds_left[2]) r.sentence_kind = KIND_GPGGA;
			end
			r.computed_checksum = xor_sum;
			r.received_checksum = '0;
			r.line_length       = 9'(fill);
			if (!star_seen) begin
				r.status = STATUS_NO_STAR;
			end else if (digit_count < 2 || digit_bad) begin
				r.status = STATUS_BAD_HEX;
			end else begin
				r.received_checksum = digit_acc;
				r.status = (digit_acc == xor_sum) ? STATUS_OK : STATUS_MISMATCH;
			end
			expected_q.push_back(r);
			in_line = 1'b0;
			return;
		end
		if (pos >= 1 && pos <= 5) begin
			for (int k = 0; k < 3; k++) begin
				if (patt[k][pos-1] != c) kinds_left[k] = 1'b0;
			end
		end
		if (!star_seen) begin
			if (c == ChStar) star_seen = 1'b1;
			else xor_sum ^= c;
		end else if (digit_count < 2) begin
			is_hex = 1'b1;
			nib    = '0;
			if (c >= 8'h30 && c <= 8'h39) begin
				nib = c[3:0];
			end else if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66) begin
				nib = c[3:0] + 4'd9;
			end else begin
				is_hex = 1'b0;
			end
			if (is_hex) digit_acc = {digit_acc[3:0], nib};
			else digit_bad = 1'b1;
			digit_count++;
		end
	endfunction

	task compare_field(string name, logic [8:0] got, logic [8:0] want);
		if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// one accepted transfer on the result channel
	task check_result(result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("result with no line pending (status %0d, length %0d)",
				got.status, got.line_length));
			return;
		end
		want = expected_q.pop_front();
		checked++;
		compare_field("status", got.status, want.status);
		compare_field("sentence_kind", got.sentence_kind, want.sentence_kind);
		compare_field("computed_checksum", got.computed_checksum, want.computed_checksum);
		compare_field("received_checksum", got.received_checksum, want.received_checksum);
		compare_field("line_length", got.line_length, want.line_length);
	endtask
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LineCap     = 128;
	localparam int          ClkHalf     = 10;
	localparam int          ResetCycles = 11;
	localparam int          DrainCycles = 12;
	localparam int unsigned PhaseBytes  = 135;
	// far beyond the slowest legal run
	localparam longint      LimitNs     = 64'd20_000_000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	nsv_byte_if   rx_if ();
	nsv_result_if res_if ();

	nmea_sentence_validator #(
		.LINE_CAPACITY(LineCap)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	always #(ClkHalf) clk = ~clk;

	line_scoreboard sb;
	result_t        seen_result;

	// flow-control phases: none, sender gaps, receiver stalls, both light
	int unsigned send_idle_tbl [4] = '{0, 70, 0, 15};
	int unsigned stall_tbl     [4] = '{0, 0, 70, 15};
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned bytes_sent;
	int unsigned lines_sent;

	// both channels are sampled at the rising edge, before any update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				seen_result.status            = res_if.status;
				seen_result.sentence_kind     = res_if.sentence_kind;
				seen_result.computed_checksum = res_if.computed_checksum;
				seen_result.received_checksum = res_if.received_checksum;
				seen_result.line_length       = res_if.line_length;
				sb.check_result(seen_result);
			end
			// a byte transfer cannot produce a result in the same cycle
			if (rx_if.valid && rx_if.ready) sb.note_byte(rx_if.rx_byte);
			res_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one transfer on the byte channel, with random gaps ahead of it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input bit with_lf = 1'b1);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
		if (with_lf) send_byte(ChLf);
	endtask

	// a hex digit in random case
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(1) ? 8'h57 : 8'h37) + 8'(n);
	endfunction

	// body character: mostly printable, now and then a carriage return or any byte,
	// never a dollar, star or newline
	function automatic logic [7:0] filler_char();
		int unsigned r;
		logic [7:0]  c;
		r = $urandom_range(99);
		if (r < 3) c = ChCr;
		else if (r < 8) c = 8'($urandom_range(255));
		else c = 8'($urandom_range(8'h7E, 8'h20));
		if (c == ChDollar || c == ChStar || c == ChLf) c = 8'h2C;
		return c;
	endfunction

	// one line: a dollar, a header (a known kind, a near miss or random letters),
	// filler up to body_len, then either a proper checksum tail or a broken one
	task automatic send_line(input int unsigned body_len, input bit well_formed);
		logic [7:0]  q[$];
		string       heads [3];
		string       head;
		logic [7:0]  sum;
		logic [7:0]  c;
		logic [7:0]  bad;
		int unsigned pick;
		heads = '{"GPRMC", "GNGLL", "GPGGA"};
		pick  = $urandom_range(4);
		if (pick < 3) begin
			head = heads[pick];
		end else if (pick == 3) begin
			// near miss: one character of a known header replaced
			head = heads[$urandom_range(2)];
			head.putc($urandom_range(4), 8'($urandom_range(8'h5A, 8'h41)));
		end else begin
			head = "AAAAA";
			for (int i = 0; i < 5; i++) head.putc(i, 8'($urandom_range(8'h5A, 8'h41)));
		end
		sum = '0;
		q.push_back(ChDollar);
		for (int i = 0; i < body_len; i++) begin
			c = (i < 5) ? head[i] : filler_char();
			q.push_back(c);
			if (c != ChCr) sum ^= c;
		end
		if (well_formed) begin
			// short lines sometimes carry a wrong checksum or trailing bytes
			if (body_len <= 64 && $urandom_range(9) == 0) sum ^= 8'($urandom_range(255, 1));
			q.push_back(ChStar);
			q.push_back(hex_char(sum[7:4]));
			q.push_back(hex_char(sum[3:0]));
			if (body_len <= 64 && $urandom_range(4) == 0) begin
				repeat ($urandom_range(6, 1)) q.push_back($urandom_range(1) ? ChStar : filler_char());
			end
		end else begin
			case ($urandom_range(5))
				0: begin
					// no star at all
				end
				1: begin
					q.push_back(ChStar);
					q.push_back(hex_char(4'($urandom_range(15))));
				end
				2: begin
					case ($urandom_range(2))
						0: bad = ChStar;
						1: bad = 8'($urandom_range(8'h5A, 8'h47));
						default: bad = 8'($urandom_range(8'hFF, 8'h80));
					endcase
					q.push_back(ChStar);
					if ($urandom_range(1)) begin
						q.push_back(bad);
						q.push_back(hex_char(4'($urandom_range(15))));
					end else begin
						q.push_back(hex_char(4'($urandom_range(15))));
						q.push_back(bad);
					end
				end
				3: begin
					q.push_back(ChStar);
				end
				4: begin
					// a fresh dollar drops the line so far and starts over
					q.push_back(ChDollar);
					repeat ($urandom_range(8)) q.push_back(filler_char());
				end
				default: begin
					// raw noise: any byte, newlines and dollars included
					repeat ($urandom_range(24, 1)) q.push_back(8'($urandom_range(255)));
				end
			endcase
		end
		if ($urandom_range(1)) q.push_back(ChCr);
		q.push_back(ChLf);
		foreach (q[i]) send_byte(q[i]);
		lines_sent++;
	endtask

	initial begin
		int unsigned phase_end;
		sb            = new(LineCap);
		send_idle_pct = 0;
		stall_pct     = 0;
		bytes_sent    = 0;
		lines_sent    = 0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready  = 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bytes before any dollar are ignored, extremes included
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("x,9");
		// good checksums for GPRMC and GNGLL, upper and lower case digits
		send_text("$GPRMC*4B");
		send_text("$GNGLL*4e", 1'b0);
		send_byte(ChCr);
		send_byte(ChLf);
		// wrong checksum
		send_text("$GPGGA*00");
		// no star; kind decided on exactly six characters, or too short
		send_text("$GPRMC");
		send_text("$GPRM");
		send_text("$");
		// one digit, no digits, a non-hex digit, a second star
		send_text("$A*4");
		send_text("$A*");
		send_text("$A*G1");
		send_text("$A**1");
		// bytes after the two digits are ignored
		send_text("$A*41x*9");
		// zero byte enters the checksum and the length
		send_text("$", 1'b0);
		send_byte(8'h00);
		send_text("*00");
		// restart in the middle of a line
		send_text("$GPR", 1'b0);
		send_text("$GNGLL*4E");
		// carriage return inside a line is skipped
		send_text("$A", 1'b0);
		send_byte(ChCr);
		send_text("*41");

		// random lines, mostly well formed, under each flow-control phase
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_idle_tbl[phase];
			stall_pct     = stall_tbl[phase];
			// longest line that still fits, then one byte too many
			if (phase == 1) send_line(LineCap - 6, 1'b1);
			if (phase == 2) send_line(LineCap - 5, 1'b1);
			phase_end = bytes_sent + PhaseBytes;
			while (bytes_sent < phase_end) begin
				send_line($urandom_range(40), $urandom_range(99) < 75);
			end
		end
		rx_if.valid <= 1'b0;

		// let the last newline be noted, then wait out the pipeline
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d bytes in %0d random lines plus directed cases", bytes_sent, lines_sent);
		$display("checked %0d line results under four flow-control phases", sb.checked);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(LimitNs);
		$display("timeout with %0d results outstanding", sb.expected_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
